// ===== hw/rtl/sbfd_pkg.sv =====
// Shared types and constants for the serial frame channel decoder.
`timescale 1ns / 1ps

package sbfd_pkg;

  localparam int FRAME_BYTES  = 25;
  localparam int POS_W        = 5;
  localparam int CHAN_BITS    = 11;
  localparam int DATA_BYTES   = 22;
  localparam int STREAM_BITS  = DATA_BYTES * 8;
  localparam int SCALE_BITS   = 32;
  localparam int PROD_BITS    = SCALE_BITS + CHAN_BITS;
  localparam int PCT_SHIFT    = 16;
  localparam int PCT_BITS     = 15;
  localparam int PERCENT_MAX  = 25600;
  localparam int CFG_IDX_W    = 3;

  localparam logic [POS_W-1:0] POS_HEADER    = POS_W'(0);
  localparam logic [POS_W-1:0] POS_DATA_LAST = POS_W'(DATA_BYTES);
  localparam logic [POS_W-1:0] POS_FOOTER    = POS_W'(FRAME_BYTES - 1);

  localparam logic [CFG_IDX_W-1:0] CFG_HEADER = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FOOTER = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE  = 3'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MUL,
    ST_OUT
  } sbfd_state_t;

endpackage

// ===== hw/rtl/sbfd_mul.sv =====
// Bit-serial scale multiplier with shift and saturation of the percentage.
`timescale 1ns / 1ps

module sbfd_mul import sbfd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [CHAN_BITS-1:0]  diff,
  input  logic [SCALE_BITS-1:0] scale,
  output logic                  done,
  output logic [PCT_BITS-1:0]   pct
);

  localparam int CNT_W = $clog2(CHAN_BITS + 1);

  logic [PROD_BITS-1:0]           acc_r;
  logic [CHAN_BITS-1:0]           mpl_r;
  logic [CNT_W-1:0]               cnt_r;
  logic                           busy_r;
  logic                           done_r;
  logic [PROD_BITS-PCT_SHIFT-1:0] hi;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(CHAN_BITS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // MSB first: shift the product left, add the scale when the bit is set
  always_ff @(posedge clk) begin
    if (start) begin
      acc_r <= '0;
      mpl_r <= diff;
    end else if (busy_r) begin
      acc_r <= {acc_r[PROD_BITS-2:0], 1'b0} +
               (mpl_r[CHAN_BITS-1] ? PROD_BITS'(scale) : '0);
      mpl_r <= {mpl_r[CHAN_BITS-2:0], 1'b0};
    end
  end

  assign hi   = acc_r[PROD_BITS-1:PCT_SHIFT];
  assign pct  = (hi > (PROD_BITS-PCT_SHIFT)'(PERCENT_MAX)) ? PCT_BITS'(PERCENT_MAX)
                                                             : hi[PCT_BITS-1:0];
  assign done = done_r;

endmodule

// ===== hw/rtl/sbus_frame_channel_decoder_unit.sv =====
// Top level of the serial frame channel decoder.
`timescale 1ns / 1ps

// Takes one received byte per item and keeps a 25-byte frame position that
// wraps without resynchronising. Bytes are taken one a cycle while no frame is
// being decoded. When the 25th byte completes a frame whose first byte matches
// the header register and whose last byte matches the footer register, input
// is held off and NUM_CHANNELS channel items are produced in order. Each
// channel passes through a load step that unpacks and clamps the 11-bit value,
// the bit-serial scale multiplier, a step that collects the product, and the
// output, which waits for out_ready. A bad frame produces nothing. The user must
// write configuration only while idle; the block does not enforce this. Unknown
// register indexes are ignored.

module sbus_frame_channel_decoder_unit import sbfd_pkg::*; #(
  parameter int NUM_CHANNELS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [SCALE_BITS-1:0] cfg_wr_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            in_data_byte,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [3:0]            out_channel_index,
  output logic [CHAN_BITS-1:0]  out_raw_value,
  output logic [PCT_BITS-1:0]   out_percent_q8,
  output logic                  out_last_channel
);

  sbfd_state_t state_r, state_nxt;

  logic [7:0]             header_r;
  logic [7:0]             footer_r;
  logic [CHAN_BITS-1:0]   min_r;
  logic [CHAN_BITS-1:0]   max_r;
  logic [SCALE_BITS-1:0]  scale_r;

  logic [POS_W-1:0]       pos_r;
  logic [7:0]             hdr_byte_r;
  logic [STREAM_BITS-1:0] stream_r;
  logic [3:0]             chan_r;
  logic [CHAN_BITS-1:0]   raw_r;
  logic [PCT_BITS-1:0]    pct_r;

  logic                   in_acc;
  logic                   frame_ok;
  logic                   is_last;
  logic                   mul_start;
  logic                   mul_done;
  logic [PCT_BITS-1:0]    mul_pct;
  logic [CHAN_BITS-1:0]   raw_in;
  logic [CHAN_BITS-1:0]   clamped;
  logic [CHAN_BITS-1:0]   diff;

  assign in_acc   = in_valid && in_ready;
  assign frame_ok = (pos_r == POS_FOOTER) && (hdr_byte_r == header_r) &&
                    (in_data_byte == footer_r);
  assign is_last  = (chan_r == 4'(NUM_CHANNELS - 1));

  // Clamp below first, then above; inverted limits give a zero difference
  assign raw_in  = stream_r[CHAN_BITS-1:0];
  assign clamped = (raw_in < min_r) ? min_r : ((raw_in > max_r) ? max_r : raw_in);
  assign diff    = (clamped >= min_r) ? (clamped - min_r) : '0;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_acc && frame_ok) state_nxt = ST_LOAD;
      ST_LOAD: state_nxt = ST_MUL;
      ST_MUL:  if (mul_done) state_nxt = ST_OUT;
      ST_OUT:  if (out_ready) state_nxt = is_last ? ST_IDLE : ST_LOAD;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    mul_start = 1'b0;
    unique case (state_r)
      ST_IDLE: in_ready  = 1'b1;
      ST_LOAD: mul_start = 1'b1;
      ST_MUL:  ;
      ST_OUT:  out_valid = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      pos_r    <= '0;
      chan_r   <= '0;
      header_r <= 8'd15;
      footer_r <= 8'd0;
      min_r    <= CHAN_BITS'(172);
      max_r    <= CHAN_BITS'(1811);
      scale_r  <= SCALE_BITS'(1023625);
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_HEADER: header_r <= cfg_wr_data[7:0];
          CFG_FOOTER: footer_r <= cfg_wr_data[7:0];
          CFG_MIN:    min_r    <= cfg_wr_data[CHAN_BITS-1:0];
          CFG_MAX:    max_r    <= cfg_wr_data[CHAN_BITS-1:0];
          CFG_SCALE:  scale_r  <= cfg_wr_data;
          default:    ;
        endcase
      end
      if (in_acc) begin
        pos_r  <= (pos_r == POS_FOOTER) ? '0 : pos_r + 1'b1;
        chan_r <= '0;
      end else if (state_r == ST_OUT && out_ready) begin
        chan_r <= chan_r + 1'b1;
      end
    end
  end

  // Frame bytes one to twenty-two form the channel bit stream, lsb first
  always_ff @(posedge clk) begin
    if (in_acc && pos_r == POS_HEADER) hdr_byte_r <= in_data_byte;
    if (in_acc && pos_r != POS_HEADER && pos_r <= POS_DATA_LAST) begin
      stream_r <= {in_data_byte, stream_r[STREAM_BITS-1:8]};
    end else if (mul_start) begin
      stream_r <= {{CHAN_BITS{1'b0}}, stream_r[STREAM_BITS-1:CHAN_BITS]};
    end
    if (mul_start) raw_r <= clamped;
    if (state_r == ST_MUL && mul_done) pct_r <= mul_pct;
  end

  sbfd_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .diff  (diff),
    .scale (scale_r),
    .done  (mul_done),
    .pct   (mul_pct)
  );

  assign out_channel_index = chan_r;
  assign out_raw_value     = raw_r;
  assign out_percent_q8    = pct_r;
  assign out_last_channel  = is_last;

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the serial frame channel decoder.
`timescale 1ns / 1ps

module testbench;
  import sbfd_pkg::*;

  localparam int N_CHAN        = 16;
  localparam int STORE_N       = FRAME_BYTES - 1;
  localparam int SETTLE_CYCLES = 300;
  localparam int LONG_HOLD     = 500;
  localparam int HOLD_AFTER    = 40;
  localparam int IDLE_PCT      = 18;

  typedef struct packed {
    logic [3:0]           idx;
    logic [CHAN_BITS-1:0] raw;
    logic [PCT_BITS-1:0]  pct;
    logic                 last;
  } chan_item_t;

  typedef enum int {
    FR_RANDOM,
    FR_SPLIT,
    FR_BAD_HEADER,
    FR_BAD_FOOTER
  } frame_kind_t;

  class frame_scoreboard;
    logic [7:0]            header_val;
    logic [7:0]            footer_val;
    logic [CHAN_BITS-1:0]  min_val;
    logic [CHAN_BITS-1:0]  max_val;
    logic [SCALE_BITS-1:0] scale_val;
    int unsigned           pos;
    logic [7:0]            store [STORE_N];
    chan_item_t            expected_q [$];
    int                    errors;
    int                    checked;

    function new();
      header_val = 8'd15;
      footer_val = 8'd0;
      min_val    = 11'd172;
      max_val    = 11'd1811;
      scale_val  = 32'd1023625;
      pos        = 0;
      errors     = 0;
      checked    = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [SCALE_BITS-1:0] data);
      case (idx)
        CFG_HEADER: header_val = data[7:0];
        CFG_FOOTER: footer_val = data[7:0];
        CFG_MIN:    min_val    = data[CHAN_BITS-1:0];
        CFG_MAX:    max_val    = data[CHAN_BITS-1:0];
        CFG_SCALE:  scale_val  = data;
        default: ;
      endcase
    endfunction

    function void decode_channels();
      logic [STREAM_BITS-1:0] bits;
      logic [CHAN_BITS-1:0]   v;
      logic [CHAN_BITS-1:0]   diff;
      logic [63:0]            prod;
      chan_item_t             e;
      for (int i = 0; i < DATA_BYTES; i++) bits[i*8 +: 8] = store[i+1];
      for (int k = 0; k < N_CHAN; k++) begin
        v = bits[k*CHAN_BITS +: CHAN_BITS];
        if (v < min_val) v = min_val;
        else if (v > max_val) v = max_val;
        diff = (v >= min_val) ? v - min_val : '0;
        prod = (64'(diff) * 64'(scale_val)) >> PCT_SHIFT;
        if (prod > PERCENT_MAX) prod = PERCENT_MAX;
        e.idx  = k[3:0];
        e.raw  = v;
        e.pct  = prod[PCT_BITS-1:0];
        e.last = (k == N_CHAN - 1);
        expected_q.push_back(e);
      end
    endfunction

    function void note_byte(logic [7:0] b);
      if (pos < STORE_N) begin
        store[pos] = b;
        pos++;
      end else begin
        pos = 0;
        if (store[0] == header_val && b == footer_val) decode_channels();
      end
    endfunction

    function void check_result(chan_item_t got);
      chan_item_t e;
      checked++;
      if (expected_q.size() == 0) begin
        $error("result with no expectation: channel_index %0d", got.idx);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (got.idx !== e.idx) begin
        $error("channel_index: expected %0d, got %0d", e.idx, got.idx);
        errors++;
      end
      if (got.raw !== e.raw) begin
        $error("raw_value: expected %0d, got %0d", e.raw, got.raw);
        errors++;
      end
      if (got.pct !== e.pct) begin
        $error("percent_q8: expected %0d, got %0d", e.pct, got.pct);
        errors++;
      end
      if (got.last !== e.last) begin
        $error("last_channel: expected %0d, got %0d", e.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_HEADER;
  logic [SCALE_BITS-1:0] cfg_wr_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [7:0]            in_data_byte = 8'h00;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [3:0]            out_channel_index;
  logic [CHAN_BITS-1:0]  out_raw_value;
  logic [PCT_BITS-1:0]   out_percent_q8;
  logic                  out_last_channel;

  logic                  idle_on = 1'b1;
  int                    hold_left = 0;
  logic                  hold_done = 1'b0;

  frame_scoreboard sb = new();

  always #6 clk = ~clk;

  sbus_frame_channel_decoder_unit #(
    .NUM_CHANNELS(N_CHAN)
  ) u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_channel_index(out_channel_index),
    .out_raw_value    (out_raw_value),
    .out_percent_q8   (out_percent_q8),
    .out_last_channel (out_last_channel)
  );

  // result side: check, random back-pressure, one long hold-off while the sender waits
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_ready)
      sb.check_result({out_channel_index, out_raw_value, out_percent_q8, out_last_channel});
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && sb.checked >= HOLD_AFTER && out_valid === 1'b1 &&
                 in_valid) begin
      out_ready <= 1'b0;
      hold_left <= LONG_HOLD;
      hold_done <= 1'b1;
    end else begin
      out_ready <= !(idle_on && $urandom_range(99) < IDLE_PCT);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while (idle_on && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    do @(posedge clk); while (in_ready !== 1'b1);
    sb.note_byte(b);
  endtask

  task automatic send_frame(input frame_kind_t kind);
    logic [7:0] fb [FRAME_BYTES];
    int         r;
    for (int i = 1; i < FRAME_BYTES - 1; i++) begin
      r = $urandom_range(99);
      if (kind == FR_SPLIT) fb[i] = (i <= DATA_BYTES / 2) ? 8'h00 : 8'hFF;
      else if (r < 10) fb[i] = 8'h00;
      else if (r < 20) fb[i] = 8'hFF;
      else fb[i] = 8'($urandom);
    end
    fb[0]             = sb.header_val;
    fb[FRAME_BYTES-1] = sb.footer_val;
    if (kind == FR_BAD_HEADER) fb[0] = fb[0] ^ 8'($urandom_range(1, 255));
    if (kind == FR_BAD_FOOTER)
      fb[FRAME_BYTES-1] = fb[FRAME_BYTES-1] ^ 8'($urandom_range(1, 255));
    foreach (fb[i]) send_byte(fb[i]);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SCALE_BITS-1:0] data);
    cfg_wr_en   <= 1'b1;
    cfg_index   <= idx;
    cfg_wr_data <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  // unused upper bits of the write data carry noise
  task automatic apply_setting(input logic [7:0] hdr, input logic [7:0] ftr,
                               input logic [CHAN_BITS-1:0] lo, input logic [CHAN_BITS-1:0] hi,
                               input logic [SCALE_BITS-1:0] scale);
    logic [31:0] junk;
    junk = $urandom;
    write_reg(CFG_HEADER, {junk[31:8], hdr});
    write_reg(CFG_FOOTER, {junk[23:0], ftr});
    write_reg(CFG_MIN, {junk[31:11], lo});
    write_reg(CFG_MAX, {junk[20:0], hi});
    write_reg(CFG_SCALE, scale);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int                   r;
    logic [CHAN_BITS-1:0] lo;
    logic [CHAN_BITS-1:0] hi;
    frame_kind_t          kind;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: both channel extremes, then a bad header
    send_frame(FR_SPLIT);
    send_frame(FR_BAD_HEADER);
    wait_idle();

    for (int ph = 1; ph <= 5; ph++) begin
      case (ph)
        1: begin
          for (int j = int'(CFG_SCALE) + 1; j < (1 << CFG_IDX_W); j++)
            write_reg(CFG_IDX_W'(j), $urandom);
          apply_setting(8'h00, 8'hFF, '0, '1, 32'hFFFF_FFFF);
        end
        2: apply_setting(8'hFF, 8'h00, '1, '0, $urandom);
        3: begin
          lo = CHAN_BITS'($urandom_range(0, 1000));
          hi = CHAN_BITS'($urandom_range(int'(lo) + 1, 2047));
          apply_setting(8'($urandom), 8'($urandom), lo, hi,
                        32'((64'd100 << 24) / 64'(hi - lo)));
        end
        4: apply_setting(8'($urandom), 8'($urandom), CHAN_BITS'($urandom),
                         CHAN_BITS'($urandom), $urandom);
        default: begin
          lo = CHAN_BITS'($urandom);
          apply_setting(8'($urandom), 8'($urandom), lo, lo, '0);
        end
      endcase
      idle_on <= (ph != 3);
      for (int n = 0; n < 3; n++) begin
        r = $urandom_range(99);
        kind = (r < 80) ? FR_RANDOM : (r < 90) ? FR_BAD_HEADER : FR_BAD_FOOTER;
        send_frame(kind);
      end
      wait_idle();
    end

    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
